// ----- rtl/core/hex_text_to_bytes_top_assert.svh -----
// Assertion macros for the hex text decoder checker.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef HEX_TEXT_TO_BYTES_TOP_ASSERT_SVH
`define HEX_TEXT_TO_BYTES_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define HXB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hex_text_to_bytes check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define HXB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hex_text_to_bytes check failed");

`endif

// ----- rtl/core/hxb_pkg.sv -----
// Package for the hex text decoder: state and result types, status codes,
// character classification functions. No dependencies.
`timescale 1ns / 1ps

package hxb_pkg;

    localparam int CHAR_W = 16;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_INVALID = 2'd1,
        STATUS_ODD     = 2'd2
    } status_t;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 16'h0030;
    localparam logic [CHAR_W-1:0] CH_NINE  = 16'h0039;
    localparam logic [CHAR_W-1:0] CH_LA    = 16'h0061;
    localparam logic [CHAR_W-1:0] CH_LF_HEX = 16'h0066;
    localparam logic [CHAR_W-1:0] CH_UA    = 16'h0041;
    localparam logic [CHAR_W-1:0] CH_UF    = 16'h0046;
    localparam logic [CHAR_W-1:0] CH_LX    = 16'h0078;
    localparam logic [CHAR_W-1:0] CH_UX    = 16'h0058;
    localparam logic [CHAR_W-1:0] CH_SPACE = 16'h0020;
    localparam logic [CHAR_W-1:0] CH_TAB   = 16'h0009;
    localparam logic [CHAR_W-1:0] CH_COMMA = 16'h002C;
    localparam logic [CHAR_W-1:0] CH_COLON = 16'h003A;
    localparam logic [CHAR_W-1:0] CH_DASH  = 16'h002D;
    localparam logic [CHAR_W-1:0] CH_NL    = 16'h000A;
    localparam logic [CHAR_W-1:0] CH_CR    = 16'h000D;

    // Decoder state carried between beats.
    typedef struct packed {
        logic [3:0] high_nibble;
        logic       nibble_waiting;
        logic       zero_held;
        logic       failed;
    } state_t;

    // One result beat.
    typedef struct packed {
        logic       has_result;
        logic       byte_valid;
        logic [7:0] byte_value;
        logic       done_res;
        status_t    status;
    } result_t;

    function automatic logic is_skip(input logic [CHAR_W-1:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_COMMA, CH_COLON, CH_DASH, CH_NL, CH_CR};
    endfunction

    function automatic logic is_x(input logic [CHAR_W-1:0] c);
        return c inside {CH_LX, CH_UX};
    endfunction

    // Bit 4 flags a hex digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_digit(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        d = '0;
        if (c inside {[CH_ZERO:CH_NINE]})
        begin
            d = c - CH_ZERO;
            return {1'b1, d[3:0]};
        end
        else if (c inside {[CH_LA:CH_LF_HEX]})
        begin
            d = c - CH_LA + 16'd10;
            return {1'b1, d[3:0]};
        end
        else if (c inside {[CH_UA:CH_UF]})
        begin
            d = c - CH_UA + 16'd10;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

// ----- rtl/core/hxb_step.sv -----
// Per-character decode step: next state and result for one input beat.
// Depends on hxb_pkg.
`timescale 1ns / 1ps

module hxb_step
(
    input  hxb_pkg::state_t           cur,
    input  logic [hxb_pkg::CHAR_W-1:0] char_code,
    input  logic                      char_present,
    input  logic                      text_end,
    output hxb_pkg::state_t           nxt,
    output hxb_pkg::result_t          res
);

    logic       active;
    logic       nw_eff;
    logic [3:0] hn_eff;
    logic [4:0] dig;
    logic       got;
    logic [7:0] bval;
    logic       odd;

    always_comb
    begin
        nxt    = cur;
        got    = 1'b0;
        bval   = 8'd0;
        odd    = 1'b0;
        active = !cur.failed && char_present;
        dig    = hxb_pkg::hex_digit(char_code);
        // a held '0' that is not a prefix becomes the high nibble
        nw_eff = cur.zero_held | cur.nibble_waiting;
        hn_eff = cur.zero_held ? 4'd0 : cur.high_nibble;

        if (active)
        begin
            if (cur.zero_held && hxb_pkg::is_x(char_code))
            begin
                nxt.zero_held = 1'b0;
            end
            else
            begin
                nxt.zero_held      = 1'b0;
                nxt.nibble_waiting = nw_eff;
                nxt.high_nibble    = hn_eff;
                if (hxb_pkg::is_skip(char_code))
                begin
                    // separator, nothing to do
                end
                else if (!nw_eff && char_code == hxb_pkg::CH_ZERO)
                begin
                    nxt.zero_held = 1'b1;
                end
                else if (dig[4])
                begin
                    if (nw_eff)
                    begin
                        got                = 1'b1;
                        bval               = {hn_eff, dig[3:0]};
                        nxt.nibble_waiting = 1'b0;
                        nxt.high_nibble    = 4'd0;
                    end
                    else
                    begin
                        nxt.high_nibble    = dig[3:0];
                        nxt.nibble_waiting = 1'b1;
                    end
                end
                else
                begin
                    nxt.failed = 1'b1;
                end
            end
        end

        res.has_result = got || text_end;
        res.byte_valid = got;
        res.byte_value = bval;
        res.done_res   = text_end;
        res.status     = hxb_pkg::STATUS_OK;

        if (text_end)
        begin
            odd = !nxt.failed && (nxt.zero_held || nxt.nibble_waiting);
            if (nxt.failed)
            begin
                res.status = hxb_pkg::STATUS_INVALID;
            end
            else if (odd)
            begin
                res.status = hxb_pkg::STATUS_ODD;
            end
            nxt = '0;
        end
    end

endmodule

// ----- rtl/core/hex_text_to_bytes_top.sv -----
// Hex text decoder top level: state registers, decode step, two-deep result buffer.
// Depends on hxb_pkg and hxb_step.
// A result is registered into the output slot, or into the skid slot while the output stalls.
// Throughput: one character per cycle; in_ready drops only when both result
// slots are full, so beats that give no result keep flowing while one waits.
// Reset (rst_n low, asynchronous): decoder state cleared, result buffer empty.
`timescale 1ns / 1ps

module hex_text_to_bytes_top
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] char_code,
    input  logic        char_present,
    input  logic        text_end,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        byte_valid,
    output logic [7:0]  byte_value,
    output logic        done_res,
    output logic [1:0]  status
);

    // Decoder state: high nibble, waiting flag, held '0' lookahead, failure flag.
    hxb_pkg::state_t  state_reg;
    hxb_pkg::state_t  state_next;
    hxb_pkg::result_t step_res;

    // Output slot feeds the ports; skid slot catches a result while output stalls.
    hxb_pkg::result_t out_reg;
    hxb_pkg::result_t skid_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;

    logic in_beat;
    logic push;
    logic pop;

    hxb_step u_step
    (
        .cur          (state_reg),
        .char_code    (char_code),
        .char_present (char_present),
        .text_end     (text_end),
        .nxt          (state_next),
        .res          (step_res)
    );

    // Ready comes straight from a register: only a full skid slot blocks input.
    assign in_ready = !skid_valid_reg;
    assign in_beat  = in_valid && in_ready;
    assign push     = in_beat && step_res.has_result;
    assign pop      = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (in_beat)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // no push possible here: in_ready is low
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload slots, no reset needed.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_reg <= step_res;
            end
            else
            begin
                out_reg <= step_res;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign byte_valid = out_reg.byte_valid;
    assign byte_value = out_reg.byte_value;
    assign done_res   = out_reg.done_res;
    assign status     = out_reg.status;

endmodule

// ----- rtl/core/hxb_checker.sv -----
// Port-level checker for hex_text_to_bytes_top, bound to it below.
// Depends on hex_text_to_bytes_top_assert.svh and hxb_pkg.
`timescale 1ns / 1ps

`include "hex_text_to_bytes_top_assert.svh"

module hxb_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        text_end,
    input logic        out_valid,
    input logic        out_ready,
    input logic        byte_valid,
    input logic [7:0]  byte_value,
    input logic        done_res,
    input logic [1:0]  status
);

    // every result beat carries a byte or closes the text
    `HXB_ASSERT_NOW(a_result_has_content, out_valid, byte_valid || done_res)

    // status is zero unless the beat closes the text
    `HXB_ASSERT_NOW(a_status_only_on_done, out_valid && !done_res, status == hxb_pkg::STATUS_OK)

    // byte value is zero when no byte is carried
    `HXB_ASSERT_NOW(a_byte_zero_when_absent, out_valid && !byte_valid, byte_value == 8'd0)

    // a stalled result beat holds
    `HXB_ASSERT_NEXT(a_out_holds, out_valid && !out_ready, out_valid && $stable(byte_value) && $stable(status))

    // after the closing beat is accepted, a result beat is on the output in the next cycle
    `HXB_ASSERT_NEXT(a_close_gives_result, in_valid && in_ready && text_end, out_valid)

endmodule

bind hex_text_to_bytes_top hxb_checker u_hxb_checker (.*);
